[design/sdx_pkg.sv]
// Shared types, constants and letter-class table for the Soundex code generator.
// No dependencies; imported by sdx_ctrl, sdx_datapath and soundex_code_generator.
package sdx_pkg;

    // Default number of characters in one code
    localparam int DEFAULT_CODE_LENGTH = 4;

    // Character constants
    localparam logic [7:0] PAD_CHAR   = 8'h30;   // ASCII '0', also the digit base
    localparam logic [7:0] CASE_BIT   = 8'h20;   // add to a capital to lower it
    localparam logic [7:0] UPPER_LO   = 8'h41;   // 'A'
    localparam logic [7:0] UPPER_HI   = 8'h5A;   // 'Z'
    localparam logic [7:0] LOWER_LO   = 8'h61;   // 'a'
    localparam logic [7:0] LOWER_HI   = 8'h7A;   // 'z'

    // Class codes
    localparam logic [2:0] CLASS_SILENT = 3'd0;  // vowels and h, w, y
    localparam logic [2:0] CLASS_UNDEF  = 3'd7;  // no class kept yet

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // take the input transaction
        logic load_pad;    // emit one pad character
        logic rearm;       // restart for the next string
    } sdx_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register empty or draining this cycle
        logic item_last;   // input transaction ends the string
        logic item_full;   // code complete after the current input
        logic pad_full;    // code complete after the current pad
    } sdx_status_t;

    // Class of a letter, indexed by its position in the alphabet (0 = a)
    function automatic logic [2:0] letter_class(input logic [4:0] idx);
        logic [2:0] cls;
        case (idx)
            5'd1, 5'd5, 5'd15, 5'd21:                          cls = 3'd1;
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: cls = 3'd2;
            5'd3, 5'd19:                                        cls = 3'd3;
            5'd11:                                              cls = 3'd4;
            5'd12, 5'd13:                                       cls = 3'd5;
            5'd17:                                              cls = 3'd6;
            default:                                            cls = CLASS_SILENT;
        endcase
        return cls;
    endfunction

endpackage

[design/sdx_ctrl.sv]
// Controller state machine of the Soundex code generator.
// Depends on sdx_pkg; drives sdx_datapath through command and status structs.
module sdx_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sdx_pkg::sdx_status_t status,
    output sdx_pkg::sdx_cmd_t    cmd
);
    import sdx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PAD  = 2'b10
    } sdx_state_t;

    sdx_state_t state_reg;
    sdx_state_t state_next;

    // Accept input only while not padding and the output register can take a result
    assign s_tready = (state_reg == ST_IDLE) && status.out_free;

    // Issue commands and pick the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = s_tvalid && s_tready;
                if (cmd.load_item && status.item_last)
                begin
                    if (status.item_full)
                    begin
                        cmd.rearm = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.load_pad = status.out_free;
                if (cmd.load_pad && status.pad_full)
                begin
                    cmd.rearm  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/sdx_datapath.sv]
// Datapath of the Soundex code generator: letter classing, code state and output register.
// Depends on sdx_pkg; commanded by sdx_ctrl.
module sdx_datapath #(
    parameter int CODE_LENGTH = sdx_pkg::DEFAULT_CODE_LENGTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           char_byte,
    input  logic                 end_of_string,
    input  sdx_pkg::sdx_cmd_t    cmd,
    output sdx_pkg::sdx_status_t status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [7:0]           code_byte,
    output logic                 code_last
);
    import sdx_pkg::*;

    localparam int CW = $clog2(CODE_LENGTH + 1);
    localparam logic [CW-1:0] LEN = CW'(CODE_LENGTH);

    logic          first_reg;
    logic          first_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [2:0]    prev_reg;
    logic [2:0]    prev_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic          is_upper;
    logic          is_letter;
    logic [2:0]    cls;
    logic          emit;
    logic [7:0]    item_byte;
    logic [CW-1:0] count_item;
    logic [CW-1:0] count_pad;

    // Class the incoming byte; both cases share the low five bits
    assign is_upper  = (char_byte >= UPPER_LO) && (char_byte <= UPPER_HI);
    assign is_letter = is_upper || ((char_byte >= LOWER_LO) && (char_byte <= LOWER_HI));
    assign cls       = is_letter ? letter_class(char_byte[4:0] - 5'd1) : CLASS_UNDEF;

    // Decide whether the input yields a code character
    always_comb
    begin
        if (first_reg)
        begin
            emit       = 1'b1;
            item_byte  = is_upper ? (char_byte + CASE_BIT) : char_byte;
            count_item = CW'(1);
        end
        else
        begin
            emit       = (count_reg < LEN) && is_letter && (cls != CLASS_SILENT)
                         && (cls != prev_reg);
            item_byte  = PAD_CHAR + {5'b0, cls};
            count_item = count_reg + CW'(emit);
        end
    end

    assign count_pad = count_reg + CW'(1);

    // Report to the controller
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.item_last = end_of_string;
    assign status.item_full = (count_item == LEN);
    assign status.pad_full  = (count_pad == LEN);

    // Update code state and the output register
    always_comb
    begin
        first_next     = first_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.load_item)
        begin
            first_next = 1'b0;
            count_next = count_item;
            if (first_reg)
            begin
                prev_next = cls;
            end
            else if (emit)
            begin
                prev_next = cls;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = item_byte;
                out_last_next  = (count_item == LEN);
            end
        end
        if (cmd.load_pad)
        begin
            count_next     = count_pad;
            out_valid_next = 1'b1;
            out_byte_next  = PAD_CHAR;
            out_last_next  = (count_pad == LEN);
        end
        if (cmd.rearm)
        begin
            first_next = 1'b1;
            count_next = '0;
            prev_next  = CLASS_UNDEF;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            count_reg     <= '0;
            prev_reg      <= CLASS_UNDEF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid  = out_valid_reg;
    assign code_byte = out_byte_reg;
    assign code_last = out_last_reg;

endmodule

[design/soundex_code_generator.sv]
// Top level of the Soundex code generator: stream ports, controller and datapath.
// Depends on sdx_pkg, sdx_ctrl and sdx_datapath.
//
// Takes one string character per input transaction and returns its Soundex code of
// CODE_LENGTH characters on the output stream, the last one flagged by m_tlast. The
// first character comes out lowered; later letters give class digits '1'..'6' when
// the class changes; the final character (s_tlast) pads a short code with '0'.
// A character is taken while the single output register is free or draining. After
// the final character, pad characters go out one at a time (up to CODE_LENGTH - 1)
// as the output frees, during which the padding sequencer holds s_tready low.
module soundex_code_generator #(
    parameter int CODE_LENGTH = sdx_pkg::DEFAULT_CODE_LENGTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_byte
    input  logic       s_tlast,    // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] code_byte
    output logic       m_tlast     // code_last
);
    import sdx_pkg::*;

    sdx_cmd_t    cmd;
    sdx_status_t status;

    // Sequence input and padding
    sdx_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Class characters and hold the result
    sdx_datapath #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_byte     (s_tdata),
        .end_of_string (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .code_byte     (m_tdata),
        .code_last     (m_tlast)
    );

endmodule
